FILE: hdl/cll_pkg.sv
package cll_pkg;

    localparam int LEVEL_W       = 18;
    localparam int FRACTION_BITS = 16;
    localparam int CH_W          = 16;
    localparam int STOP_TOTAL    = 11;
    localparam int MAP_TOTAL     = 6;
    localparam int MAP_W         = 3;
    localparam int IDX_W         = $clog2(STOP_TOTAL);
    localparam int T_W           = FRACTION_BITS + 1;
    localparam int SCALED_W      = FRACTION_BITS + IDX_W;
    localparam int WEIGHT_W      = FRACTION_BITS + 1;
    localparam int PROD_W        = CH_W + FRACTION_BITS;
    localparam int SUM_W         = PROD_W + 1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // position of one item along the map
    typedef struct packed {
        logic [MAP_W-1:0]         map;
        logic [IDX_W-1:0]         idx;
        logic [FRACTION_BITS-1:0] frac;
        logic                     last;
    } t_pos;

    localparam t_rgb STOP_ROM [MAP_TOTAL][STOP_TOTAL] = '{
        '{  // viridis
            '{16'd17498, 16'd319,   16'd21589}, '{16'd18522, 16'd9236,  16'd29984},
            '{16'd16642, 16'd17384, 16'd34733}, '{16'd13550, 16'd24364, 16'd36249},
            '{16'd10723, 16'd30876, 16'd36579}, '{16'd8360,  16'd37156, 16'd36081},
            '{16'd8827,  16'd43164, 16'd33925}, '{16'd17494, 16'd49070, 16'd28873},
            '{16'd31294, 16'd53834, 16'd20853}, '{16'd48588, 16'd57242, 16'd9802},
            '{16'd65094, 16'd59386, 16'd9433}
        },
        '{  // magma
            '{16'd96,    16'd31,    16'd909},   '{16'd5165,  16'd3551,  16'd13872},
            '{16'd15209, 16'd3925,  16'd28685}, '{16'd25584, 16'd6578,  16'd32890},
            '{16'd36064, 16'd10562, 16'd33143}, '{16'd46949, 16'd14089, 16'd31149},
            '{16'd56937, 16'd18857, 16'd26824}, '{16'd63417, 16'd28816, 16'd23581},
            '{16'd65191, 16'd40917, 16'd28010}, '{16'd65253, 16'd53262, 16'd37529},
            '{16'd64688, 16'd64975, 16'd49119}
        },
        '{  // inferno
            '{16'd96,    16'd31,    16'd909},   '{16'd5729,  16'd2920,  16'd14733},
            '{16'd16924, 16'd2528,  16'd26639}, '{16'd27285, 16'd5912,  16'd28373},
            '{16'd37900, 16'd9702,  16'd26503}, '{16'd48214, 16'd14150, 16'd21643},
            '{16'd56689, 16'd20763, 16'd14815}, '{16'd62555, 16'd30720, 16'd6545},
            '{16'd64725, 16'd42292, 16'd2614},  '{16'd63203, 16'd55302, 16'd17917},
            '{16'd64773, 16'd65429, 16'd42266}
        },
        '{  // plasma
            '{16'd3302,  16'd1953,  16'd34601}, '{16'd16687, 16'd910,   16'd40332},
            '{16'd27371, 16'd37,    16'd43148}, '{16'd36880, 16'd3378,  16'd42042},
            '{16'd45406, 16'd10823, 16'd36997}, '{16'd52312, 16'd18363, 16'd30772},
            '{16'd57766, 16'd25725, 16'd25115}, '{16'd62208, 16'd33932, 16'd19377},
            '{16'd64767, 16'd42751, 16'd13852}, '{16'd64792, 16'd53057, 16'd9526},
            '{16'd61605, 16'd63908, 16'd8607}
        },
        '{  // cividis
            '{16'd0,     16'd8855,  16'd19972}, '{16'd2104,  16'd13186, 16'd28887},
            '{16'd13692, 16'd17862, 16'd27840}, '{16'd20290, 16'd22308, 16'd27839},
            '{16'd26307, 16'd26987, 16'd28882}, '{16'd32027, 16'd31806, 16'd30868},
            '{16'd38148, 16'd36613, 16'd30679}, '{16'd44823, 16'd41864, 16'd29114},
            '{16'd51509, 16'd47215, 16'd26189}, '{16'd58774, 16'd53152, 16'd21036},
            '{16'd65257, 16'd59595, 16'd14272}
        },
        '{  // turbo
            '{16'd12449, 16'd4703,  16'd15215}, '{16'd17673, 16'd22858, 16'd52187},
            '{16'd16008, 16'd39936, 16'd65337}, '{16'd6390,  16'd54863, 16'd52653},
            '{16'd18086, 16'd63630, 16'd33851}, '{16'd42180, 16'd64880, 16'd15307},
            '{16'd57889, 16'd56723, 16'd14234}, '{16'd65278, 16'd42125, 16'd12560},
            '{16'd61659, 16'd23309, 16'd4608},  '{16'd50119, 16'd9420,  16'd682},
            '{16'd31431, 16'd1037,  16'd691}
        }
    };

endpackage

FILE: hdl/cll_front.sv
module cll_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [cll_pkg::LEVEL_W-1:0] i_level,
    input  logic [cll_pkg::MAP_W-1:0]   i_map,
    output logic                       o_valid,
    input  logic                       i_ready,
    output cll_pkg::t_pos              o_pos
);
    import cll_pkg::*;

    localparam logic [T_W-1:0] ONE = T_W'(1) << FRACTION_BITS;

    logic                r_v1;
    logic [T_W-1:0]      r_t;
    logic [MAP_W-1:0]    r_map;
    logic [T_W-1:0]      n_t;
    logic                ready1;

    logic                r_v2;
    t_pos                r_pos;
    t_pos                n_pos;
    logic                ready2;
    logic [SCALED_W-1:0] scaled;

    // clamp to [0, 1.0]
    always_comb begin
        if (i_level[LEVEL_W-1]) begin
            n_t = '0;
        end else if (T_W'(i_level[LEVEL_W-2:0]) > ONE) begin
            n_t = ONE;
        end else begin
            n_t = T_W'(i_level[LEVEL_W-2:0]);
        end
    end

    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r_t   <= n_t;
            r_map <= i_map;
        end
    end

    // scale by the number of stop intervals
    always_comb begin
        scaled     = SCALED_W'(r_t) * SCALED_W'(STOP_TOTAL - 1);
        n_pos.map  = r_map;
        n_pos.idx  = scaled[SCALED_W-1 -: IDX_W];
        n_pos.frac = scaled[FRACTION_BITS-1:0];
        n_pos.last = (scaled[SCALED_W-1 -: IDX_W] >= IDX_W'(STOP_TOTAL - 1));
    end

    assign ready2 = !r_v2 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_pos <= n_pos;
        end
    end

    assign o_valid = r_v2;
    assign o_pos   = r_pos;

endmodule

FILE: hdl/cll_blend.sv
module cll_blend (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cll_pkg::t_pos i_pos,
    output logic          o_valid,
    input  logic          i_ready,
    output cll_pkg::t_rgb o_color
);
    import cll_pkg::*;

    localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << FRACTION_BITS;

    logic                     r_v3;
    t_rgb                     r_a;
    t_rgb                     r_b;
    logic [FRACTION_BITS-1:0] r_frac;
    logic                     ready3;
    logic [IDX_W-1:0]         b_idx;

    logic                     r_v4;
    logic [PROD_W-1:0]        r_pa [3];
    logic [PROD_W-1:0]        r_pb [3];
    logic                     ready4;
    logic [WEIGHT_W-1:0]      wa;
    logic [CH_W-1:0]          a_ch [3];
    logic [CH_W-1:0]          b_ch [3];

    logic                     r_v5;
    logic [CH_W-1:0]          r_ch [3];
    logic                     ready5;

    // at full scale both ends of the blend are the last stop
    assign b_idx  = i_pos.last ? i_pos.idx : i_pos.idx + IDX_W'(1);
    assign ready3 = !r_v3 || ready4;
    assign o_ready = ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && i_valid) begin
            r_a    <= STOP_ROM[i_pos.map][i_pos.idx];
            r_b    <= STOP_ROM[i_pos.map][b_idx];
            r_frac <= i_pos.frac;
        end
    end

    assign wa      = ONE - WEIGHT_W'(r_frac);
    assign a_ch[0] = r_a.red;
    assign a_ch[1] = r_a.green;
    assign a_ch[2] = r_a.blue;
    assign b_ch[0] = r_b.red;
    assign b_ch[1] = r_b.green;
    assign b_ch[2] = r_b.blue;
    assign ready4  = !r_v4 || ready5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (ready4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4 && r_v3) begin
            for (int c = 0; c < 3; c++) begin
                r_pa[c] <= PROD_W'(a_ch[c]) * PROD_W'(wa);
                r_pb[c] <= PROD_W'(b_ch[c]) * PROD_W'(r_frac);
            end
        end
    end

    assign ready5 = !r_v5 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (ready5) begin
            r_v5 <= r_v4;
        end
    end

    // weighted sum, truncated back to a channel
    always_ff @(posedge i_clk) begin
        if (ready5 && r_v4) begin
            for (int c = 0; c < 3; c++) begin
                r_ch[c] <= CH_W'((SUM_W'(r_pa[c]) + SUM_W'(r_pb[c])) >> FRACTION_BITS);
            end
        end
    end

    assign o_valid       = r_v5;
    assign o_color.red   = r_ch[0];
    assign o_color.green = r_ch[1];
    assign o_color.blue  = r_ch[2];

endmodule

FILE: hdl/colormap_lerp_lookup.sv
// Scalar-to-RGB colormap. Each item carries a signed Q2.16 level that is
// clamped to [0, 1.0] and placed along one of six built-in 11-stop maps
// (0 viridis, 1 magma, 2 inferno, 3 plasma, 4 cividis, 5 turbo); the map
// register picks one, and codes 6 and 7 select viridis. Red, green and
// blue come out as unsigned Q0.16, linearly blended between the two
// neighboring stops and truncated. Throughput is one item per clock;
// items pass through the clamp, scale, stop lookup, multiply and sum
// stages, and each stage holds its item while the output stalls.
// The map register resets to 0 and should be written only between items.
module colormap_lerp_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cll_pkg::MAP_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [cll_pkg::LEVEL_W-1:0] i_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cll_pkg::CH_W-1:0]      o_red,
    output logic [cll_pkg::CH_W-1:0]      o_green,
    output logic [cll_pkg::CH_W-1:0]      o_blue
);
    import cll_pkg::*;

    logic [MAP_W-1:0] r_map_select;
    logic [MAP_W-1:0] map_eff;
    logic             front_valid;
    logic             blend_ready;
    t_pos             front_pos;
    t_rgb             color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_select <= '0;
        end else if (i_cfg_valid) begin
            r_map_select <= i_cfg_data;
        end
    end

    // unknown map codes fall back to the first map
    assign map_eff = (r_map_select >= MAP_W'(MAP_TOTAL)) ? '0 : r_map_select;

    cll_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_level (i_level),
        .i_map   (map_eff),
        .o_valid (front_valid),
        .i_ready (blend_ready),
        .o_pos   (front_pos)
    );

    cll_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (blend_ready),
        .i_pos   (front_pos),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_color (color)
    );

    assign o_red   = color.red;
    assign o_green = color.green;
    assign o_blue  = color.blue;

    // an empty output stage means nothing upstream can be blocked
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready
    ) else $error("input stalled with empty output stage");

    a_stop_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> (front_pos.idx <= IDX_W'(STOP_TOTAL - 1)) &&
                        (!front_pos.last || (front_pos.frac == '0))
    ) else $error("stop index or fraction out of range");

    a_map_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> (front_pos.map < MAP_W'(MAP_TOTAL))
    ) else $error("map number out of range in pipeline");

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import cll_pkg::*;

    localparam int BUILTIN_MAPS = 6;
    localparam int LAST_STOP    = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_color;

    // published map values rounded to Q0.16, rows are stops, columns r g b
    localparam logic [15:0] MAP_STOPS [BUILTIN_MAPS][LAST_STOP+1][3] = '{
        '{  // viridis
            '{17498, 319, 21589}, '{18522, 9236, 29984}, '{16642, 17384, 34733},
            '{13550, 24364, 36249}, '{10723, 30876, 36579}, '{8360, 37156, 36081},
            '{8827, 43164, 33925}, '{17494, 49070, 28873}, '{31294, 53834, 20853},
            '{48588, 57242, 9802}, '{65094, 59386, 9433}
        },
        '{  // magma
            '{96, 31, 909}, '{5165, 3551, 13872}, '{15209, 3925, 28685},
            '{25584, 6578, 32890}, '{36064, 10562, 33143}, '{46949, 14089, 31149},
            '{56937, 18857, 26824}, '{63417, 28816, 23581}, '{65191, 40917, 28010},
            '{65253, 53262, 37529}, '{64688, 64975, 49119}
        },
        '{  // inferno
            '{96, 31, 909}, '{5729, 2920, 14733}, '{16924, 2528, 26639},
            '{27285, 5912, 28373}, '{37900, 9702, 26503}, '{48214, 14150, 21643},
            '{56689, 20763, 14815}, '{62555, 30720, 6545}, '{64725, 42292, 2614},
            '{63203, 55302, 17917}, '{64773, 65429, 42266}
        },
        '{  // plasma
            '{3302, 1953, 34601}, '{16687, 910, 40332}, '{27371, 37, 43148},
            '{36880, 3378, 42042}, '{45406, 10823, 36997}, '{52312, 18363, 30772},
            '{57766, 25725, 25115}, '{62208, 33932, 19377}, '{64767, 42751, 13852},
            '{64792, 53057, 9526}, '{61605, 63908, 8607}
        },
        '{  // cividis
            '{0, 8855, 19972}, '{2104, 13186, 28887}, '{13692, 17862, 27840},
            '{20290, 22308, 27839}, '{26307, 26987, 28882}, '{32027, 31806, 30868},
            '{38148, 36613, 30679}, '{44823, 41864, 29114}, '{51509, 47215, 26189},
            '{58774, 53152, 21036}, '{65257, 59595, 14272}
        },
        '{  // turbo
            '{12449, 4703, 15215}, '{17673, 22858, 52187}, '{16008, 39936, 65337},
            '{6390, 54863, 52653}, '{18086, 63630, 33851}, '{42180, 64880, 15307},
            '{57889, 56723, 14234}, '{65278, 42125, 12560}, '{61659, 23309, 4608},
            '{50119, 9420, 682}, '{31431, 1037, 691}
        }
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [MAP_W-1:0]           i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [LEVEL_W-1:0]  i_level;
    logic                       o_valid;
    logic                       i_ready;
    logic [CH_W-1:0]            o_red;
    logic [CH_W-1:0]            o_green;
    logic [CH_W-1:0]            o_blue;

    t_color           pending_colors[$];
    logic [MAP_W-1:0] map_code;
    int               sender_idle_pct;
    int               recv_stall_pct;
    int               mismatch_count;
    int               colors_checked;
    int               levels_sent;
    int               levels_below_zero;
    int               levels_above_one;
    int               cycle_count;

    colormap_lerp_lookup u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_level     (i_level),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic t_color predict_color(input logic signed [LEVEL_W-1:0] lv,
                                             input logic [MAP_W-1:0] code);
        int          m;
        logic [16:0] clamped;
        logic [19:0] scaled;
        logic [3:0]  stop;
        logic [15:0] frac;
        logic [32:0] acc;
        logic [15:0] chan [3];
        t_color      color;
        m = (code >= BUILTIN_MAPS) ? 0 : int'(code);
        if (lv < 0) begin
            clamped = '0;
        end else if (lv > 65536) begin
            clamped = 17'h10000;
        end else begin
            clamped = lv[16:0];
        end
        scaled = 20'(clamped) * 20'd10;
        stop   = scaled[19:16];
        frac   = scaled[15:0];
        for (int c = 0; c < 3; c++) begin
            if (stop >= LAST_STOP) begin
                chan[c] = MAP_STOPS[m][LAST_STOP][c];
            end else begin
                acc = 33'(MAP_STOPS[m][stop][c]) * (33'h10000 - 33'(frac))
                    + 33'(MAP_STOPS[m][stop+1][c]) * 33'(frac);
                chan[c] = acc[31:16];
            end
        end
        color.red   = chan[0];
        color.green = chan[1];
        color.blue  = chan[2];
        return color;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] random_level();
        int pick;
        int k;
        int base;
        pick = $urandom_range(99);
        if (pick < 66) begin
            return LEVEL_W'($urandom_range(65536));
        end else if (pick < 76) begin
            return {1'b1, 17'($urandom)};
        end else if (pick < 84) begin
            return LEVEL_W'($urandom_range(131071, 65537));
        end else if (pick < 94) begin
            // just around a stop boundary
            k = $urandom_range(LAST_STOP);
            base = (k * 65536 + 9) / 10;
            return LEVEL_W'(base + int'($urandom_range(2)) - 1);
        end else begin
            return LEVEL_W'($urandom);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic send_level(input logic signed [LEVEL_W-1:0] lv);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_level = lv;
        do @(posedge i_clk); while (!o_ready);
        pending_colors.push_back(predict_color(lv, map_code));
        levels_sent++;
        if (lv < 0) begin
            levels_below_zero++;
        end else if (lv > 65536) begin
            levels_above_one++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_for_colors();
        i_valid = 1'b0;
        while (pending_colors.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_map(input logic [MAP_W-1:0] code);
        wait_for_colors();
        i_cfg_valid = 1'b1;
        i_cfg_data  = code;
        do @(posedge i_clk); while (!o_cfg_ready);
        map_code = code;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // map left at its reset value, clamp limits and stop boundaries
    task automatic test_clamp_edges();
        logic signed [LEVEL_W-1:0] edge_levels [13];
        edge_levels = '{-131072, -1, 0, 1, 6553, 6554, 32768, 58982, 58983,
                        65535, 65536, 65537, 131071};
        foreach (edge_levels[n]) begin
            send_level(edge_levels[n]);
        end
    endtask

    // unused map codes fall back to the first map; maps 5 and 1 are also sent levels
    task automatic test_map_codes();
        write_map(3'd6);
        send_level(0);
        send_level(32768);
        write_map(3'd7);
        send_level(65535);
        send_level(65536);
        write_map(3'd5);
        send_level(20000);
        send_level(131071);
        write_map(3'd1);
        send_level(45875);
    endtask

    task automatic test_random_sweep();
        for (int seg = 0; seg < 8; seg++) begin
            write_map(MAP_W'(seg));
            case (seg % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 76;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 76;
                end
                default: begin
                    sender_idle_pct = 24;
                    recv_stall_pct  = 24;
                end
            endcase
            repeat (125) send_level(random_level());
        end
    endtask

    // sender holds off until the pipeline has emptied, then resumes
    task automatic test_drain_pause();
        write_map(MAP_W'($urandom_range(7)));
        sender_idle_pct = 24;
        recv_stall_pct  = 24;
        repeat (4) begin
            repeat (10) send_level(random_level());
            wait_for_colors();
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_colors
        t_color want;
        if (i_rst_n && o_valid && i_ready) begin
            colors_checked++;
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("color with no level pending: %0d %0d %0d",
                                          o_red, o_green, o_blue));
            end else begin
                want = pending_colors.pop_front();
                if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue) begin
                    report_mismatch($sformatf(
                        "color %0d: expected %0d %0d %0d, got %0d %0d %0d",
                        colors_checked, want.red, want.green, want.blue,
                        o_red, o_green, o_blue));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("colormap_lerp_lookup: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_level           = '0;
        i_ready           = 1'b1;
        map_code          = '0;
        sender_idle_pct   = 0;
        recv_stall_pct    = 0;
        mismatch_count    = 0;
        colors_checked    = 0;
        levels_sent       = 0;
        levels_below_zero = 0;
        levels_above_one  = 0;
        cycle_count       = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_clamp_edges();
        test_map_codes();
        test_random_sweep();
        test_drain_pause();

        wait_for_colors();
        repeat (20) @(negedge i_clk);

        $display("%0d levels sent over map codes 0 to 7, %0d below zero and %0d above one",
                 levels_sent, levels_below_zero, levels_above_one);
        $display("%0d colors compared, %0d wrong", colors_checked, mismatch_count);
        if (mismatch_count == 0 && pending_colors.size() == 0) begin
            $display("colormap_lerp_lookup: match");
        end else begin
            $display("colormap_lerp_lookup: mismatch");
        end
        $finish;
    end

endmodule
